[rtl/ppf_pkg.sv]
`timescale 1ns / 1ps
// Package for the pansharpening pixel fuse: widths, method codes and the
// divider pipeline stage type. No dependencies.
package ppf_pkg;

  localparam int SAMPLE_BITS = 16;              // used bits of each sample, 8..16
  localparam int FIELD_BITS  = 16;              // width of the input fields
  localparam int OUT_BITS    = 20;              // width of the sharpened outputs
  localparam int NUM_BANDS   = 4;
  localparam int SUM_BITS    = SAMPLE_BITS + 2; // sum of four samples
  localparam int QUO_BITS    = SAMPLE_BITS + 2; // Brovey quotient, below 4*2^SAMPLE_BITS
  localparam int PROD_BITS   = 2 * SAMPLE_BITS;
  localparam int DIV_STAGES  = QUO_BITS;        // one quotient bit per stage

  typedef enum logic {
    METHOD_BROVEY = 1'b0,
    METHOD_FIHS   = 1'b1
  } method_e;

  // One item in the divider pipeline, all four bands side by side.
  typedef struct packed {
    method_e                                 method;
    logic                                    zero;
    logic [SUM_BITS-1:0]                     dvs;
    logic [NUM_BANDS-1:0][SUM_BITS-1:0]      rem;
    logic [NUM_BANDS-1:0][QUO_BITS-1:0]      nlo;
    logic [NUM_BANDS-1:0][QUO_BITS-1:0]      quo;
    logic [NUM_BANDS-1:0][OUT_BITS-1:0]      fihs;
  } div_t;

endpackage

[rtl/ppf_in_if.sv]
`timescale 1ns / 1ps
// Pixel input channel: valid/ready handshake with five samples.
// Depends on ppf_pkg.
interface ppf_in_if;
  logic                           valid;
  logic                           ready;
  logic [ppf_pkg::FIELD_BITS-1:0] red_sample;
  logic [ppf_pkg::FIELD_BITS-1:0] green_sample;
  logic [ppf_pkg::FIELD_BITS-1:0] blue_sample;
  logic [ppf_pkg::FIELD_BITS-1:0] nir_sample;
  logic [ppf_pkg::FIELD_BITS-1:0] pan_sample;

  modport source (output valid, red_sample, green_sample, blue_sample, nir_sample,
                  pan_sample, input ready);
  modport sink   (input valid, red_sample, green_sample, blue_sample, nir_sample,
                  pan_sample, output ready);
endinterface

[rtl/ppf_out_if.sv]
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with four sharpened bands and a flag.
// Depends on ppf_pkg.
interface ppf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ppf_pkg::OUT_BITS-1:0] red_sharp;
  logic signed [ppf_pkg::OUT_BITS-1:0] green_sharp;
  logic signed [ppf_pkg::OUT_BITS-1:0] blue_sharp;
  logic signed [ppf_pkg::OUT_BITS-1:0] nir_sharp;
  logic                                zero_sum;

  modport source (output valid, red_sharp, green_sharp, blue_sharp, nir_sharp,
                  zero_sum, input ready);
  modport sink   (input valid, red_sharp, green_sharp, blue_sharp, nir_sharp,
                  zero_sum, output ready);
endinterface

[rtl/pansharpen_pixel_fuse_top.sv]
`timescale 1ns / 1ps
// Pansharpening pixel fuse top level: Brovey and fast IHS per pixel.
// Depends on ppf_pkg, ppf_in_if and ppf_out_if.
//
// One pixel per cycle unless stalled; four sharpened bands out, in quarter units.
// Method 0 (Brovey) gives floor(4*band*pan/sum) and flags a zero band sum with
// all outputs 0; method 1 (fast IHS) gives 4*band + 4*pan - sum and a clear flag.
// Throughput is one item per cycle while the output is not held. The pipeline
// is an input register, a multiply/add stage, one stage per Brovey quotient
// bit (restoring compare-subtract, four lanes in parallel) and the output
// register. The method register is sampled when an item is accepted. When
// the output is held, the whole pipeline freezes and in.ready drops; nothing
// is lost or repeated.
module pansharpen_pixel_fuse_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  ppf_in_if.sink        pix_i,
  ppf_out_if.source     res_o
);
  import ppf_pkg::*;

  function automatic div_t div_step(input div_t s);
    logic [SUM_BITS:0] t;
    div_t              r;
    r = s;
    for (int b = 0; b < NUM_BANDS; b++) begin
      t = {s.rem[b], s.nlo[b][QUO_BITS-1]};
      if (t >= {1'b0, s.dvs}) begin
        r.rem[b] = SUM_BITS'(t - {1'b0, s.dvs});
        r.quo[b] = {s.quo[b][QUO_BITS-2:0], 1'b1};
      end else begin
        r.rem[b] = t[SUM_BITS-1:0];
        r.quo[b] = {s.quo[b][QUO_BITS-2:0], 1'b0};
      end
      r.nlo[b] = {s.nlo[b][QUO_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

  method_e method_q;

  logic                                  adv;
  logic                                  s0_vld_q;
  method_e                               s0_method_q;
  logic [NUM_BANDS-1:0][SAMPLE_BITS-1:0] band_q;
  logic [SAMPLE_BITS-1:0]                pan_q;

  div_t                                  dv_d0;
  div_t                                  dv_q [DIV_STAGES+1];
  logic [DIV_STAGES:0]                   dv_vld_q;

  logic                                  out_vld_q;
  logic [NUM_BANDS-1:0][OUT_BITS-1:0]    out_d, out_q;
  logic                                  flag_d, flag_q;

  // Whole pipe moves together; the output register is the only hold point.
  assign adv         = !out_vld_q || res_o.ready;
  assign pix_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= METHOD_BROVEY;
    end else if (cfg_we_i) begin
      method_q <= method_e'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q  <= 1'b0;
      dv_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q  <= pix_i.valid;
      dv_vld_q  <= {dv_vld_q[DIV_STAGES-1:0], s0_vld_q};
      out_vld_q <= dv_vld_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_method_q <= method_q;
      band_q[0]   <= pix_i.red_sample[SAMPLE_BITS-1:0];
      band_q[1]   <= pix_i.green_sample[SAMPLE_BITS-1:0];
      band_q[2]   <= pix_i.blue_sample[SAMPLE_BITS-1:0];
      band_q[3]   <= pix_i.nir_sample[SAMPLE_BITS-1:0];
      pan_q       <= pix_i.pan_sample[SAMPLE_BITS-1:0];
    end
  end

  // Products, band sum and the FIHS value; the dividend 4*band*pan is split
  // into its top SAMPLE_BITS (starting remainder) and the bits still to shift in.
  always_comb begin
    logic [SUM_BITS-1:0]  sum;
    logic [PROD_BITS-1:0] prod;
    sum = '0;
    for (int b = 0; b < NUM_BANDS; b++) begin
      sum = sum + SUM_BITS'(band_q[b]);
    end
    dv_d0        = '0;
    dv_d0.method = s0_method_q;
    dv_d0.zero   = (sum == '0);
    dv_d0.dvs    = sum;
    for (int b = 0; b < NUM_BANDS; b++) begin
      prod           = PROD_BITS'(band_q[b]) * PROD_BITS'(pan_q);
      dv_d0.rem[b]   = SUM_BITS'(prod[PROD_BITS-1:SAMPLE_BITS]);
      dv_d0.nlo[b]   = {prod[SAMPLE_BITS-1:0], 2'b00};
      dv_d0.quo[b]   = '0;
      dv_d0.fihs[b]  = OUT_BITS'({band_q[b], 2'b00}) + OUT_BITS'({pan_q, 2'b00})
                       - OUT_BITS'(sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0] <= dv_d0;
      for (int j = 1; j <= DIV_STAGES; j++) begin
        dv_q[j] <= div_step(dv_q[j-1]);
      end
    end
  end

  always_comb begin
    flag_d = 1'b0;
    for (int b = 0; b < NUM_BANDS; b++) begin
      out_d[b] = dv_q[DIV_STAGES].fihs[b];
    end
    if (dv_q[DIV_STAGES].method == METHOD_BROVEY) begin
      flag_d = dv_q[DIV_STAGES].zero;
      for (int b = 0; b < NUM_BANDS; b++) begin
        out_d[b] = flag_d ? '0 : OUT_BITS'(dv_q[DIV_STAGES].quo[b]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q  <= out_d;
      flag_q <= flag_d;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.red_sharp   = out_q[0];
  assign res_o.green_sharp = out_q[1];
  assign res_o.blue_sharp  = out_q[2];
  assign res_o.nir_sharp   = out_q[3];
  assign res_o.zero_sum    = flag_q;

endmodule

[tb/tb_pansharpen_pixel_fuse_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for pansharpen_pixel_fuse_top: Brovey and fast IHS pixel fusion.
// Depends on ppf_pkg, ppf_in_if, ppf_out_if and the top level under rtl/.
module tb_pansharpen_pixel_fuse_top;
  import ppf_pkg::*;

  localparam int LATENCY_WAIT = DIV_STAGES + 8;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 150;
  localparam int MAX_PRINTED  = 100;

  typedef struct packed {
    logic [FIELD_BITS-1:0] red;
    logic [FIELD_BITS-1:0] green;
    logic [FIELD_BITS-1:0] blue;
    logic [FIELD_BITS-1:0] nir;
    logic [FIELD_BITS-1:0] pan;
  } pixel_t;

  typedef struct packed {
    logic [NUM_BANDS-1:0][OUT_BITS-1:0] band;  // red, green, blue, nir
    logic                               zero;
  } sharp_t;

  typedef enum int {
    MIX_SMALL,
    MIX_EXTREME,
    MIX_ONE_BAND,
    MIX_DARK,
    MIX_BRIGHT_PAN,
    MIX_UNIFORM
  } mix_e;

  logic    clk_i;
  logic    rst_ni;
  logic    cfg_we_i;
  logic    cfg_wdata_i;
  method_e cur_method;

  ppf_in_if  pix ();
  ppf_out_if res ();

  pansharpen_pixel_fuse_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pix_i      (pix),
    .res_o      (res)
  );

  pixel_t pend_q[$];
  sharp_t sharp_q[$];

  int n_sent;       // items put on the input bus
  int n_acc;        // items taken by the block
  int n_got;        // results taken from the block
  int n_seen;       // results the sink has drawn a stall for
  int n_err;
  int src_gap;
  int snk_gap;
  int hold_left;
  bit src_idle;
  bit snk_idle;
  bit press_en;
  bit press_done;
  int quiet_cycles;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  task automatic note_mismatch(string msg);
    if (n_err < MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, msg);
    n_err++;
  endtask

  function automatic sharp_t fuse_pixel(method_e m, pixel_t px);
    longint unsigned bnd[NUM_BANDS];
    longint unsigned pan;
    longint unsigned sum;
    longint unsigned v;
    sharp_t r;
    r = '0;
    bnd[0] = px.red[SAMPLE_BITS-1:0];
    bnd[1] = px.green[SAMPLE_BITS-1:0];
    bnd[2] = px.blue[SAMPLE_BITS-1:0];
    bnd[3] = px.nir[SAMPLE_BITS-1:0];
    pan    = px.pan[SAMPLE_BITS-1:0];
    sum    = bnd[0] + bnd[1] + bnd[2] + bnd[3];
    for (int i = 0; i < NUM_BANDS; i++) begin
      if (m == METHOD_BROVEY) begin
        v = (sum == 0) ? 64'd0 : (64'd4 * bnd[i] * pan) / sum;
      end else begin
        v = 64'd4 * bnd[i] + 64'd4 * pan - sum;  // wraps to two's complement
      end
      r.band[i] = v[OUT_BITS-1:0];
    end
    r.zero = (m == METHOD_BROVEY) && (sum == 0);
    return r;
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    mix_e   kind;
    int     pick;
    pick = $urandom_range(0, 9);
    kind = (pick > MIX_UNIFORM) ? MIX_UNIFORM : mix_e'(pick);
    px.red   = $urandom_range(0, 65535);
    px.green = $urandom_range(0, 65535);
    px.blue  = $urandom_range(0, 65535);
    px.nir   = $urandom_range(0, 65535);
    px.pan   = $urandom_range(0, 65535);
    case (kind)
      MIX_SMALL: begin
        px.red   = $urandom_range(0, 1);
        px.green = $urandom_range(0, 1);
        px.blue  = $urandom_range(0, 1);
        px.nir   = $urandom_range(0, 1);
      end
      MIX_EXTREME: begin
        px.red   = $urandom_range(0, 1) ? '1 : '0;
        px.green = $urandom_range(0, 1) ? '1 : '0;
        px.blue  = $urandom_range(0, 1) ? '1 : '0;
        px.nir   = $urandom_range(0, 1) ? '1 : '0;
        px.pan   = $urandom_range(0, 1) ? '1 : '0;
      end
      MIX_ONE_BAND: begin
        pick = $urandom_range(0, NUM_BANDS - 1);
        if (pick != 0) px.red = '0;
        if (pick != 1) px.green = '0;
        if (pick != 2) px.blue = '0;
        if (pick != 3) px.nir = '0;
      end
      MIX_DARK: begin
        // all bands zero: Brovey flags it
        px.red   = '0;
        px.green = '0;
        px.blue  = '0;
        px.nir   = '0;
      end
      MIX_BRIGHT_PAN: begin
        px.pan = '1;
      end
      default: begin
      end
    endcase
    return px;
  endfunction

  task automatic queue_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                             logic [15:0] n, logic [15:0] p);
    pend_q.push_back('{red: r, green: g, blue: b, nir: n, pan: p});
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) pend_q.push_back(rand_pixel());
  endtask

  // Wait until everything queued has been sent and has come back out.
  task automatic drain();
    while (pend_q.size() != 0 || n_sent != n_acc || sharp_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY_WAIT) @(negedge clk_i);
  endtask

  task automatic set_method(method_e m);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_method   = m;
  endtask

  // Source side: one item on the bus at a time, random gap after each while src_idle is set.
  always @(negedge clk_i) begin
    if (rst_ni && n_sent == n_acc) begin
      if (src_gap > 0) begin
        src_gap--;
        pix.valid <= 1'b0;
      end else if (pend_q.size() != 0) begin
        pixel_t px;
        px = pend_q.pop_front();
        pix.red_sample   <= px.red;
        pix.green_sample <= px.green;
        pix.blue_sample  <= px.blue;
        pix.nir_sample   <= px.nir;
        pix.pan_sample   <= px.pan;
        pix.valid        <= 1'b1;
        n_sent++;
        src_gap = src_idle ? $urandom_range(0, 13) : 0;
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // Sink side: random stall per result while snk_idle is set, plus one long hold to back up the pipe.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (n_got != n_seen) begin
        n_seen  = n_got;
        snk_gap = snk_idle ? $urandom_range(0, 13) : 0;
      end
      if (press_en && !press_done) begin
        press_done = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // Monitor: check results in order, predict on every accepted pixel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res.valid && res.ready) begin
        n_got++;
        if (sharp_q.size() == 0) begin
          note_mismatch("result with nothing expected");
        end else begin
          sharp_t want;
          sharp_t got;
          want = sharp_q.pop_front();
          got.band[0] = res.red_sharp;
          got.band[1] = res.green_sharp;
          got.band[2] = res.blue_sharp;
          got.band[3] = res.nir_sharp;
          got.zero    = res.zero_sum;
          for (int i = 0; i < NUM_BANDS; i++) begin
            if (got.band[i] !== want.band[i])
              note_mismatch($sformatf("result %0d band %0d got %0d want %0d", n_got - 1, i,
                                      $signed(got.band[i]), $signed(want.band[i])));
          end
          if (got.zero !== want.zero)
            note_mismatch($sformatf("result %0d zero_sum got %b want %b", n_got - 1,
                                    got.zero, want.zero));
        end
      end
      if (pix.valid && pix.ready) begin
        pixel_t px;
        px = '{red: pix.red_sample, green: pix.green_sample, blue: pix.blue_sample,
               nir: pix.nir_sample, pan: pix.pan_sample};
        n_acc++;
        sharp_q.push_back(fuse_pixel(cur_method, px));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pix.valid && pix.ready) || (res.valid && res.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = 1'b0;
    cur_method       = METHOD_BROVEY;
    pix.valid        = 1'b0;
    pix.red_sample   = '0;
    pix.green_sample = '0;
    pix.blue_sample  = '0;
    pix.nir_sample   = '0;
    pix.pan_sample   = '0;
    res.ready        = 1'b0;
    n_sent = 0; n_acc = 0; n_got = 0; n_seen = 0; n_err = 0;
    src_gap = 0; snk_gap = 0; hold_left = 0; quiet_cycles = 0;
    src_idle = 1'b1; snk_idle = 1'b1; press_en = 1'b0; press_done = 1'b0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Brovey out of reset, no register write yet
    queue_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff);
    queue_pixel(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    queue_pixel(16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'hffff);
    queue_pixel(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'hffff);
    queue_pixel(16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
    queue_pixel(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
    queue_pixel(16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'h0001);
    queue_pixel(16'hffff, 16'hffff, 16'hffff, 16'h0001, 16'h8000);
    queue_pixel(16'h0003, 16'h0005, 16'h0007, 16'h000b, 16'h000d);
    drain();

    set_method(METHOD_FIHS);
    queue_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_pixel(16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'hffff);  // top of range
    queue_pixel(16'h0000, 16'hffff, 16'hffff, 16'hffff, 16'h0000);  // bottom of range
    queue_pixel(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    queue_pixel(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h0000);
    queue_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff);
    queue_pixel(16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005);
    queue_pixel(16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'h1234);
    queue_pixel(16'h8000, 16'h4000, 16'h2000, 16'h1000, 16'haaaa);
    queue_pixel(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
    drain();

    set_method(METHOD_BROVEY);
    queue_random(300);
    drain();

    // back-to-back offers against a long receiver hold
    set_method(METHOD_FIHS);
    src_idle = 1'b0;
    snk_idle = 1'b0;
    press_en = 1'b1;
    queue_random(300);
    drain();

    set_method(METHOD_BROVEY);
    src_idle = 1'b1;
    snk_idle = 1'b0;
    queue_random(175);
    drain();

    set_method(METHOD_FIHS);
    src_idle = 1'b0;
    snk_idle = 1'b1;
    queue_random(175);
    drain();

    repeat (LATENCY_WAIT) @(posedge clk_i);
    if (n_err == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
